// ----- design/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the plucked string voice
// Request kinds, stage opcodes, payload widths and arithmetic constants used
// by the channel interfaces and the voice datapath.
// ----------------------------------------------------------------------------
package pss_pkg;

   // Payload widths fixed by the channel definition
   localparam int KIND_W    = 2;
   localparam int LEN_IN_W  = 10;
   localparam int SAMPLE_W  = 8;

   // Voice constants
   localparam logic [SAMPLE_W-1:0] HOLD_RESET = 8'h80;
   localparam int LENGTH_RESET = 318;
   localparam int MIN_LENGTH   = 2;

   // Divide by three for sums up to three full-scale samples:
   // q = (sum * 683) >> 11 is exact for sum below 2048
   localparam int SUM_W        = SAMPLE_W + 2;
   localparam int RECIP_W      = 10;
   localparam logic [RECIP_W-1:0] RECIP_3 = 10'd683;
   localparam int RECIP_SHIFT  = 11;

   // Request kinds as coded on the request channel
   typedef enum logic [KIND_W-1:0] {
      KIND_STEP  = 2'd0,
      KIND_BEGIN = 2'd1,
      KIND_LOAD  = 2'd2,
      KIND_MUTE  = 2'd3
   } kind_type;

   // Work carried into the memory stage
   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_STEP,
      OP_HOLD
   } op_type;

endpackage

// ----- design/pss_if.sv -----
// ----------------------------------------------------------------------------
// pss_if: request and response channels of the plucked string voice
// Valid/ready channels; a request moves at a clock edge with valid and ready.
// ----------------------------------------------------------------------------
interface pss_req_if
   import pss_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [LEN_IN_W-1:0] string_length;
   logic [SAMPLE_W-1:0] excitation;

   modport source (output valid, output kind, output string_length, output excitation,
                   input ready);
   modport sink   (input valid, input kind, input string_length, input excitation,
                   output ready);
endinterface

interface pss_rsp_if
   import pss_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ----- design/pss_ram.sv -----
// ----------------------------------------------------------------------------
// pss_ram: generic synchronous RAM
// One write port and two read ports, read data registered under a read enable.
// ----------------------------------------------------------------------------
module pss_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read both ports, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ----- design/plucked_string_synth.sv -----
// ----------------------------------------------------------------------------
// plucked_string_synth: plucked string voice on a circular delay line
// Each step averages the previous sample with the current and next entries.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries requests: kind 0 steps one sample, 1 begins a note with
//   string_length (clamped to 2..MAX_LENGTH), 2 loads one excitation sample
//   at the load pointer, 3 mutes the voice. Load the excitation after begin.
//   rsp_bus returns one sample for every step request and nothing for the
//   other kinds; results come back in request order.
//   A request is accepted every cycle while the result path flows. Pointer
//   and mute state update at intake; the delay line lives in a two-read,
//   one-write RAM that is read at intake and written as the memory stage
//   advances, with a forward path for a read of the entry being written.
//   A step sample passes the memory stage to wait in the output register.
//   When the receiver stalls with a sample waiting, the memory stage holds
//   its own step and intake stops; begin, load and mute requests behind a
//   non-emitting stage still flow.
//   Reset (synchronous, active high) mutes the voice, sets the length to 318
//   (or MAX_LENGTH if smaller), clears both pointers and sets the held
//   sample to 0x80. Delay line contents stay undefined until loaded; no
//   clearing pass is run.
// ----------------------------------------------------------------------------
module plucked_string_synth
   import pss_pkg::*;
#(
   parameter int MAX_LENGTH = 512
) (
   input  logic         clock,
   input  logic         reset,
   pss_req_if.sink      req_bus,
   pss_rsp_if.source    rsp_bus
);

   localparam int AW = $clog2(MAX_LENGTH);
   localparam int LW = $clog2(MAX_LENGTH + 1);
   localparam int CW = (LW > LEN_IN_W) ? LW : LEN_IN_W;
   localparam int RESET_LEN = (LENGTH_RESET > MAX_LENGTH) ? MAX_LENGTH : LENGTH_RESET;
   localparam int PROD_W = SUM_W + RECIP_W;

   // Architectural control state
   logic [AW-1:0]       read_index_ff,    read_index_in;
   logic [LW-1:0]       load_index_ff,    load_index_in;
   logic [LW-1:0]       active_length_ff, active_length_in;
   logic                muted_ff,         muted_in;
   logic [SAMPLE_W-1:0] prev_sample_ff,   prev_sample_in;

   // Memory stage
   logic                s1_valid_ff;
   op_type              s1_op_ff,       s1_op_in;
   logic [AW-1:0]       s1_addr_ff,     s1_addr_in;
   logic [SAMPLE_W-1:0] s1_exc_ff;
   logic                s1_fwd_cur_ff,  s1_fwd_cur_in;
   logic                s1_fwd_next_ff, s1_fwd_next_in;
   logic [SAMPLE_W-1:0] s1_fwd_data_ff;

   // Output register
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_sample_ff;

   kind_type            req_kind;
   logic                req_fire;
   logic                s1_adv;
   logic                s1_emit;
   logic                s1_wr_en;
   logic [SAMPLE_W-1:0] s1_wr_data;
   logic [SAMPLE_W-1:0] s1_sample;
   logic [CW-1:0]       len_wide;
   logic [LW-1:0]       len_clamped;
   logic [LW-1:0]       cur_ext;
   logic [LW-1:0]       next_sum;
   logic [LW-1:0]       next_ext;
   logic [SAMPLE_W-1:0] ram_cur;
   logic [SAMPLE_W-1:0] ram_next;
   logic [SAMPLE_W-1:0] cur_val;
   logic [SAMPLE_W-1:0] next_val;
   logic [SUM_W-1:0]    tap_sum;
   logic [PROD_W-1:0]   tap_prod;
   logic [SAMPLE_W-1:0] tap_avg;

   assign req_kind = kind_type'(req_bus.kind);

   // Flow control: the memory stage moves unless its sample has no room
   assign s1_emit       = (s1_op_ff == OP_STEP) || (s1_op_ff == OP_HOLD);
   assign s1_adv        = s1_valid_ff && (!s1_emit || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Clamp the requested string length
   assign len_wide = CW'(req_bus.string_length);
   always_comb begin
      priority if (len_wide < CW'(MIN_LENGTH)) begin
         len_clamped = LW'(MIN_LENGTH);
      end else if (len_wide > CW'(MAX_LENGTH)) begin
         len_clamped = LW'(MAX_LENGTH);
      end else begin
         len_clamped = len_wide[LW-1:0];
      end
   end

   // Current and next tap addresses, wrapping at the string length
   assign cur_ext  = (LW'(read_index_ff) < active_length_ff) ? LW'(read_index_ff) : '0;
   assign next_sum = cur_ext + LW'(1);
   assign next_ext = (next_sum >= active_length_ff) ? '0 : next_sum;

   // Decode the request at intake
   always_comb begin
      read_index_in    = read_index_ff;
      load_index_in    = load_index_ff;
      active_length_in = active_length_ff;
      muted_in         = muted_ff;
      s1_op_in         = OP_NONE;
      s1_addr_in       = cur_ext[AW-1:0];
      if (req_fire) begin
         unique case (req_kind)
            KIND_STEP: begin
               if (muted_ff) begin
                  s1_op_in = OP_HOLD;
               end else begin
                  s1_op_in      = OP_STEP;
                  read_index_in = next_ext[AW-1:0];
               end
            end
            KIND_BEGIN: begin
               active_length_in = len_clamped;
               read_index_in    = '0;
               load_index_in    = '0;
               muted_in         = 1'b0;
            end
            KIND_LOAD: begin
               if (load_index_ff < active_length_ff) begin
                  s1_op_in      = OP_LOAD;
                  s1_addr_in    = load_index_ff[AW-1:0];
                  load_index_in = load_index_ff + LW'(1);
               end
            end
            KIND_MUTE: begin
               muted_in = 1'b1;
            end
         endcase
      end
   end

   // Forward a write landing in the same cycle as the taps are read
   assign s1_fwd_cur_in  = s1_wr_en && (s1_addr_ff == cur_ext[AW-1:0]);
   assign s1_fwd_next_in = s1_wr_en && (s1_addr_ff == next_ext[AW-1:0]);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff    <= '0;
         load_index_ff    <= '0;
         active_length_ff <= LW'(RESET_LEN);
         muted_ff         <= 1'b1;
         prev_sample_ff   <= HOLD_RESET;
      end else begin
         read_index_ff    <= read_index_in;
         load_index_ff    <= load_index_in;
         active_length_ff <= active_length_in;
         muted_ff         <= muted_in;
         prev_sample_ff   <= prev_sample_in;
      end
   end

   // Advance the memory stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_fire && (s1_op_in != OP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff       <= s1_op_in;
         s1_addr_ff     <= s1_addr_in;
         s1_exc_ff      <= req_bus.excitation;
         s1_fwd_cur_ff  <= s1_fwd_cur_in;
         s1_fwd_next_ff <= s1_fwd_next_in;
         s1_fwd_data_ff <= s1_wr_data;
      end
   end

   // Delay line
   pss_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_LENGTH)
   ) u_delay (
      .clock     (clock),
      .wr_en     (s1_wr_en),
      .wr_addr   (s1_addr_ff),
      .wr_data   (s1_wr_data),
      .rd_en     (req_fire),
      .rd_addr_a (cur_ext[AW-1:0]),
      .rd_addr_b (next_ext[AW-1:0]),
      .rd_data_a (ram_cur),
      .rd_data_b (ram_next)
   );

   // Average the three taps
   assign cur_val  = s1_fwd_cur_ff  ? s1_fwd_data_ff : ram_cur;
   assign next_val = s1_fwd_next_ff ? s1_fwd_data_ff : ram_next;
   assign tap_sum  = SUM_W'(prev_sample_ff) + SUM_W'(cur_val) + SUM_W'(next_val);
   assign tap_prod = PROD_W'(tap_sum) * PROD_W'(RECIP_3);
   assign tap_avg  = tap_prod[RECIP_SHIFT +: SAMPLE_W];

   // Write back and update the held sample
   assign s1_wr_en   = s1_adv && ((s1_op_ff == OP_LOAD) || (s1_op_ff == OP_STEP));
   assign s1_wr_data = (s1_op_ff == OP_LOAD) ? s1_exc_ff : tap_avg;
   assign s1_sample  = (s1_op_ff == OP_STEP) ? cur_val : prev_sample_ff;

   always_comb begin
      prev_sample_in = prev_sample_ff;
      if (s1_adv) begin
         unique case (s1_op_ff)
            OP_LOAD: prev_sample_in = s1_exc_ff;
            OP_STEP: prev_sample_in = cur_val;
            OP_HOLD, OP_NONE: prev_sample_in = prev_sample_ff;
         endcase
      end
   end

   // Hold the result until taken
   assign out_valid_in = (s1_adv && s1_emit) || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_emit) begin
         out_sample_ff <= s1_sample;
      end
   end

   assign rsp_bus.valid  = out_valid_ff;
   assign rsp_bus.sample = out_sample_ff;

`ifndef NO_ASSERTIONS
   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      LW'(read_index_ff) < active_length_ff)
      else $error("read pointer outside the string");

   a_load_in_range: assert property (@(posedge clock) disable iff (reset)
      load_index_ff <= active_length_ff)
      else $error("load pointer past the string end");

   a_stall_keeps_step: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_emit && out_valid_ff && !rsp_bus.ready) |=> s1_valid_ff)
      else $error("stalled sample dropped from memory stage");

   a_emit_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_emit) |=> out_valid_ff)
      else $error("emitted sample missing from output register");
`endif

endmodule

// ----- tb/sv/plucked_string_synth_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plucked_string_synth_tb: self-checking bench of the plucked string voice
// Drives begin, load, step and mute requests over the valid/ready request
// channel, predicts every step sample from a cycle-free model of the string
// state and compares each returned sample in order. Directed tests cover the
// field extremes and clamping cases; random notes then run under three
// idling patterns of sender and receiver.
// ----------------------------------------------------------------------------
module plucked_string_synth_tb;
   import pss_pkg::*;

   localparam int MAX_LEN      = 512;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_ITEMS = 450;

   logic clock = 1'b0;
   logic reset;

   pss_req_if req_bus ();
   pss_rsp_if rsp_bus ();

   plucked_string_synth #(
      .MAX_LENGTH (MAX_LEN)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #10 clock = ~clock;

   // Predicted string state
   logic [SAMPLE_W-1:0] string_line [MAX_LEN];
   bit                  entry_written [MAX_LEN];
   logic [SAMPLE_W-1:0] held_sample;
   int                  read_pos;
   int                  load_pos;
   int                  note_length;
   bit                  voice_muted;

   logic [SAMPLE_W-1:0] pending_samples [$];
   logic [SAMPLE_W-1:0] expected_sample;

   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int fail_count;
   int quiet_cycles;

   function automatic int fit_length(input int len);
      if (len < MIN_LENGTH) return MIN_LENGTH;
      if (len > MAX_LEN) return MAX_LEN;
      return len;
   endfunction

   // Update the string state for one accepted request; queue the step sample
   function automatic void advance_string(input kind_type k, input int len,
                                          input logic [SAMPLE_W-1:0] exc);
      int cur;
      int nxt;
      int sum;
      case (k)
         KIND_BEGIN: begin
            note_length = fit_length(len);
            read_pos    = 0;
            load_pos    = 0;
            voice_muted = 1'b0;
         end
         KIND_LOAD: begin
            // drop loads past the end of the string
            if (load_pos < note_length) begin
               string_line[load_pos]   = exc;
               entry_written[load_pos] = 1'b1;
               held_sample             = exc;
               load_pos++;
            end
         end
         KIND_MUTE: begin
            voice_muted = 1'b1;
         end
         default: begin
            if (!voice_muted) begin
               cur = (read_pos < note_length) ? read_pos : 0;
               nxt = (cur + 1 >= note_length) ? 0 : cur + 1;
               sum = held_sample + string_line[cur] + string_line[nxt];
               held_sample      = string_line[cur];
               string_line[cur] = SAMPLE_W'(sum / 3);
               read_pos         = (cur + 1 >= note_length) ? 0 : cur + 1;
            end
            pending_samples.push_back(held_sample);
         end
      endcase
   endfunction

   // A step may only read entries that have been loaded at some point
   function automatic bit entries_ready();
      int cur;
      int nxt;
      if (voice_muted) return 1'b1;
      cur = (read_pos < note_length) ? read_pos : 0;
      nxt = (cur + 1 >= note_length) ? 0 : cur + 1;
      return entry_written[cur] && entry_written[nxt];
   endfunction

   // Present one request, wait for its handshake, then predict it
   task automatic send_request(input kind_type k, input int len,
                               input logic [SAMPLE_W-1:0] exc);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.kind          <= k;
      req_bus.string_length <= LEN_IN_W'(len);
      req_bus.excitation    <= exc;
      do @(posedge clock); while (!req_bus.ready);
      advance_string(k, len, exc);
      items_sent++;
   endtask

   task automatic send_steps(input int count);
      repeat (count) send_request(KIND_STEP, 0, '0);
   endtask

   // Check each returned sample against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected sample: actual %0d", rsp_bus.sample);
            fail_count++;
         end else begin
            expected_sample = pending_samples.pop_front();
            if (rsp_bus.sample !== expected_sample) begin
               $error("sample mismatch: expected %0d, actual %0d",
                      expected_sample, rsp_bus.sample);
               fail_count++;
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Stop the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** plucked_string_synth: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Muted voice after reset holds the reset sample
   task automatic test_muted_hold();
      send_steps(1);
   endtask

   // Length zero clamps to two; extreme samples; load past the end
   task automatic test_short_string();
      send_request(KIND_BEGIN, 0, '0);
      send_request(KIND_LOAD, 0, 8'hFF);
      send_request(KIND_LOAD, 0, 8'h00);
      send_request(KIND_LOAD, 0, 8'h07);
      send_steps(4);
   endtask

   // Length one clamps to two as well
   task automatic test_length_one();
      send_request(KIND_BEGIN, 1, '0);
      send_request(KIND_LOAD, 0, 8'h80);
      send_request(KIND_LOAD, 0, 8'h01);
      send_steps(3);
   endtask

   // Mute freezes the voice; steps keep returning the held sample
   task automatic test_mute_hold();
      send_request(KIND_BEGIN, 5, '0);
      send_request(KIND_LOAD, 0, 8'h00);
      send_request(KIND_LOAD, 0, 8'hFF);
      send_request(KIND_LOAD, 0, 8'h11);
      send_request(KIND_LOAD, 0, 8'hC8);
      send_request(KIND_LOAD, 0, 8'h63);
      send_steps(2);
      send_request(KIND_MUTE, 0, '0);
      send_steps(2);
   endtask

   // Oversized length clamps to the full line; fill it and load past the end
   task automatic test_max_length();
      send_request(KIND_BEGIN, 1023, '0);
      repeat (MAX_LEN + 1) send_request(KIND_LOAD, 0, SAMPLE_W'($urandom_range(0, 255)));
      send_steps(8);
      send_request(KIND_BEGIN, MAX_LEN, '0);
      send_steps(6);
      send_request(KIND_BEGIN, MAX_LEN + 1, '0);
      send_steps(4);
   endtask

   // One well-formed note: begin, excitation, steps, maybe a mute
   task automatic play_random_note();
      int pick;
      int len_in;
      int len;
      int need;
      int loads;
      int steps;
      int mute_at;
      pick = $urandom_range(0, 99);
      if (pick < 70) len_in = $urandom_range(0, 16);
      else if (pick < 95) len_in = $urandom_range(17, 64);
      else len_in = $urandom_range(65, 1023);
      len  = fit_length(len_in);
      need = 0;
      for (int i = 0; i < len; i++) begin
         if (!entry_written[i]) need = i + 1;
      end
      if (len > 64) loads = need + $urandom_range(0, 4);
      else loads = $urandom_range(need, len + 2);
      steps   = (len > 64) ? $urandom_range(1, 200) : $urandom_range(1, 3 * len + 4);
      mute_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, steps - 1) : -1;
      send_request(KIND_BEGIN, len_in, '0);
      repeat (loads) send_request(KIND_LOAD, 0, SAMPLE_W'($urandom_range(0, 255)));
      for (int s = 0; s < steps; s++) begin
         if (s == mute_at) send_request(KIND_MUTE, 0, '0);
         send_request(KIND_STEP, 0, '0);
      end
   endtask

   // Unstructured request; swap a step that would read a blank entry for a mute
   task automatic send_noise();
      kind_type k;
      k = kind_type'($urandom_range(0, 3));
      if (k == KIND_STEP && !entries_ready()) k = KIND_MUTE;
      send_request(k, $urandom_range(0, 1023), SAMPLE_W'($urandom_range(0, 255)));
   endtask

   task automatic test_random_notes(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(0, 99) < 85) play_random_note();
         else repeat ($urandom_range(1, 4)) send_noise();
      end
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.kind          <= KIND_STEP;
      req_bus.string_length <= '0;
      req_bus.excitation    <= '0;
      send_idle_pct = 20;
      recv_idle_pct = 59;
      items_sent    = 0;
      held_sample   = HOLD_RESET;
      read_pos      = 0;
      load_pos      = 0;
      note_length   = fit_length(LENGTH_RESET);
      voice_muted   = 1'b1;
      for (int i = 0; i < MAX_LEN; i++) begin
         string_line[i]   = '0;
         entry_written[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_muted_hold();
      test_short_string();
      test_length_one();
      test_mute_hold();
      test_max_length();

      test_random_notes(RANDOM_ITEMS / 3);
      send_idle_pct = 59;
      recv_idle_pct = 20;
      test_random_notes(RANDOM_ITEMS / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_notes(RANDOM_ITEMS / 3);

      // Drain the remaining samples
      req_bus.valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("** plucked_string_synth: PASSED **");
      end else begin
         $display("** plucked_string_synth: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/pss_pkg.sv
design/pss_if.sv
design/pss_ram.sv
design/plucked_string_synth.sv
tb/sv/plucked_string_synth_tb.sv
